### rtl/core/tfpd_pkg.sv
// ----------------------------------------------------------------------------
// tfpd_pkg
// shared constants, register indexes and helper functions of the tilt drive
// ----------------------------------------------------------------------------
package tfpd_pkg;

   localparam int TABLE_LEN = 24;

   // register indexes on the csr port
   localparam logic [3:0] REG_GAIN_P       = 4'd0;
   localparam logic [3:0] REG_GAIN_I       = 4'd1;
   localparam logic [3:0] REG_GAIN_D       = 4'd2;
   localparam logic [3:0] REG_DRIVE_LIMIT  = 4'd3;
   localparam logic [3:0] REG_BLEND_WEIGHT = 4'd4;
   localparam logic [3:0] REG_MAG_LOW      = 4'd5;
   localparam logic [3:0] REG_MAG_HIGH     = 4'd6;

   // drive direction codes
   localparam logic [1:0] DIR_HOLD     = 2'd0;
   localparam logic [1:0] DIR_FORWARD  = 2'd1;
   localparam logic [1:0] DIR_BACKWARD = 2'd2;

   localparam logic signed [47:0] ANGLE_LIMIT = 48'sd11796480;
   localparam logic signed [27:0] QUARTER_TURN = 28'sd5898240;
   localparam logic [41:0] PERIOD_NUM = 42'd3932160000;

   // ceil(2^36/205) and ceil(2^36/25), quotient taken from product bits 62:36
   localparam logic [31:0] GYRO_RECIP  = 32'd335216960;
   localparam logic [31:0] INTEG_RECIP = 32'd2748779070;

   typedef struct packed {
      logic       start;
      logic [41:0] num;
      logic [23:0] den;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [41:0] quo;
      logic       rem_nz;
   } div_rsp_type;

   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] r;
      case (i)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117265;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [47:0] clamp_s(input logic signed [47:0] v,
                                                 input logic signed [47:0] lim);
      logic signed [47:0] r;
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      else r = v;
      return r;
   endfunction

endpackage

### rtl/core/tfpd_divider.sv
// ----------------------------------------------------------------------------
// tfpd_divider
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tfpd_divider
   import tfpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int NUM_W = 42;

   logic [NUM_W-1:0] n_ff, n_in;
   logic [23:0]      r_ff, r_in;
   logic [23:0]      den_ff, den_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [24:0]      sh;
   logic             fit;

   assign sh  = {r_ff, n_ff[NUM_W-1]};
   assign fit = sh >= {1'b0, den_ff};

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         n_in    = req.num;
         r_in    = '0;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[NUM_W-2:0], fit};
         r_in   = fit ? 24'(sh - {1'b0, den_ff}) : sh[23:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.quo    = n_ff;
   assign rsp.rem_nz = r_ff != '0;

endmodule

### rtl/core/tfpd_cordic.sv
// ----------------------------------------------------------------------------
// tfpd_cordic
// vectoring cordic atan2, one rotation step per cycle
// ----------------------------------------------------------------------------
module tfpd_cordic
   import tfpd_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] y_in,
   input  logic signed [15:0] x_in,
   output logic               done,
   output logic signed [24:0] angle
);

   localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic signed [27:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [27:0] xs, ys, x0, y0;
   logic signed [27:0] z_ff, z_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [47:0] z_sat;

   assign x0 = {{4{x_in[15]}}, x_in, 8'd0};
   assign y0 = {{4{y_in[15]}}, y_in, 8'd0};
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   always_comb begin
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = '0;
         if (x_in == 16'sd0 && y_in == 16'sd0) begin
            z_in    = '0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (x0 < 0) begin
               // pre-rotate into the right half plane
               if (y0 >= 0) begin
                  x_in_nx = y0;
                  y_in_nx = -x0;
                  z_in    = QUARTER_TURN;
               end else begin
                  x_in_nx = -y0;
                  y_in_nx = x0;
                  z_in    = -QUARTER_TURN;
               end
            end else begin
               x_in_nx = x0;
               y_in_nx = y0;
               z_in    = '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_nx = x_ff + ys;
            y_in_nx = y_ff - xs;
            z_in    = z_ff + $signed({6'd0, atan_entry(5'(cnt_ff))});
         end else begin
            x_in_nx = x_ff - ys;
            y_in_nx = y_ff + xs;
            z_in    = z_ff - $signed({6'd0, atan_entry(5'(cnt_ff))});
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_nx;
      y_ff   <= y_in_nx;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign z_sat = clamp_s(48'(z_ff), ANGLE_LIMIT);
   assign angle = z_sat[24:0];
   assign done  = done_ff;

endmodule

### rtl/core/tilt_fusion_pid_drive.sv
// ----------------------------------------------------------------------------
// tilt_fusion_pid_drive
// gyro/accel tilt fusion with cordic atan2 and a pid drive, on one sequencer
// ----------------------------------------------------------------------------
//  channel  direction  handshake            content
//  req      in         req_valid/req_stall  accel x/y/z, gyro x/y
//  rsp      out        rsp_valid/rsp_stall  angles, drive, period, direction
//  csr      in         csr_valid/csr_ready  register index and write data
//
//  without blending, a sample runs from acceptance to rsp_valid through the
//  two reciprocal-multiply gyro steps, the pid and the serial period divide
//  with the output load; zero drive skips the divide, and blending adds a
//  cordic atan2 and a blend multiply-add for each axis.
//  req_stall is high from acceptance until the result is loaded into the
//  output register; a stalled result holds the block before that load.
//  reset is synchronous and restores register defaults and zero state.
// ----------------------------------------------------------------------------
module tilt_fusion_pid_drive
   import tfpd_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_pitch_out,
   output logic signed [24:0] rsp_roll_out,
   output logic signed [23:0] rsp_drive_value,
   output logic [15:0]        rsp_step_period,
   output logic [1:0]         rsp_drive_direction,
   output logic               rsp_accel_blended,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_G_MUL, S_G_ADD, S_C_START, S_C_WAIT, S_B_MUL1, S_B_MUL2, S_B_SUM,
      S_K_P, S_K_I, S_I_MUL, S_I_ADD, S_K_D, S_D_SUM, S_DRIVE,
      S_PER_START, S_PER_WAIT, S_OUT
   } state_type;

   state_type state_ff;

   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, weight_ff;
   logic [22:0] limit_ff;
   logic [16:0] mag_low_ff, mag_high_ff;

   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic               blend_ff, axis_ff, neg_ff;
   logic signed [24:0] pitch_ff, roll_ff, prev_ff, acc_ff;
   logic signed [23:0] integ_ff, drive_ff;
   logic signed [43:0] prod_ff, bsum_ff;
   logic signed [33:0] p_ff;
   logic signed [41:0] d_ff;
   logic [15:0]        period_ff;
   logic [26:0]        rq_ff;

   logic signed [25:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [43:0] qs;
   logic [16:0]        mag;
   logic signed [24:0] ang_sel;
   logic signed [47:0] lim_s, sat_v, blend_v, integ_v, drive_v, d_t;
   logic [23:0]        absd;

   logic signed [15:0] gyro_sel;
   logic signed [28:0] gyro_m;
   logic signed [35:0] integ_m, integ_h;
   logic [30:0]        rec_u;
   logic [31:0]        rec_m;
   logic               rec_neg;
   logic [62:0]        rec_prod;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               cor_start, cor_done;
   logic signed [24:0] cor_angle;

   function automatic logic [16:0] abs16(input logic signed [15:0] v);
      return v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
   endfunction

   assign mag = abs16(req_accel_x) + abs16(req_accel_y) + abs16(req_accel_z);
   assign ang_sel = axis_ff ? roll_ff : pitch_ff;
   assign lim_s = $signed({25'd0, limit_ff});
   assign absd = drive_ff[23] ? 24'(-drive_ff) : drive_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = 26'(pitch_ff);
      mul_b = '0;
      case (state_ff)
         S_B_MUL1: begin
            mul_a = 26'(ang_sel);
            mul_b = $signed({2'b0, weight_ff});
         end
         S_B_MUL2: begin
            mul_a = 26'(acc_ff);
            mul_b = $signed({1'b0, 17'(18'h10000 - {2'b0, weight_ff})});
         end
         S_K_P: mul_b = $signed({2'b0, gain_p_ff});
         S_K_I: mul_b = $signed({2'b0, gain_i_ff});
         S_K_D: begin
            mul_a = 26'(pitch_ff) - 26'(prev_ff);
            mul_b = $signed({2'b0, gain_d_ff});
         end
         default: ;
      endcase
   end

   // gyro step: (g*65536+1640)/3280 is (g*4096+102)/205 after a floor by 16
   assign gyro_sel = axis_ff ? gy_ff : gx_ff;
   assign gyro_m   = 29'($signed({gyro_sel, 12'd0})) + 29'sd102;
   // integral step: (e*ki+6400)/12800 is ((e*ki>>8)+25)/50, split as /2 then /25
   assign integ_m  = 36'(prod_ff >>> 8) + 36'sd25;
   assign integ_h  = integ_m >>> 1;

   // shared reciprocal multiplier, floor on negatives by biasing the magnitude
   always_comb begin
      rec_neg = integ_h[35];
      rec_u   = integ_h[35] ? 31'(36'sd24 - integ_h) : integ_h[30:0];
      rec_m   = INTEG_RECIP;
      if (state_ff == S_G_MUL) begin
         rec_neg = gyro_m[28];
         rec_u   = gyro_m[28] ? 31'(29'sd204 - gyro_m) : {2'b0, gyro_m};
         rec_m   = GYRO_RECIP;
      end
   end

   assign rec_prod = 63'(rec_u) * 63'(rec_m);

   // the serial divider only serves the step period
   assign div_req.start = state_ff == S_PER_START;
   assign div_req.num   = PERIOD_NUM;
   assign div_req.den   = absd;

   assign qs = neg_ff ? -$signed({17'd0, rq_ff}) : $signed({17'd0, rq_ff});

   assign sat_v   = clamp_s(48'(ang_sel) + 48'(qs), ANGLE_LIMIT);
   assign blend_v = clamp_s(48'((bsum_ff + prod_ff + 44'sd32768) >>> 16), ANGLE_LIMIT);
   assign integ_v = clamp_s(48'(integ_ff) + 48'(qs), lim_s);
   assign d_t     = ((48'(prod_ff) <<< 5) + (48'(prod_ff) <<< 4) + (48'(prod_ff) <<< 1)
                     + 48'sd128) >>> 8;
   assign drive_v = clamp_s(48'(p_ff) + 48'(integ_ff) + 48'(d_ff), lim_s);

   assign cor_start = state_ff == S_C_START;

   tfpd_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tfpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .y_in  (axis_ff ? ax_ff : ay_ff),
      .x_in  (az_ff),
      .done  (cor_done),
      .angle (cor_angle)
   );

   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff    <= S_IDLE;
         gain_p_ff   <= 16'd307;
         gain_i_ff   <= 16'd0;
         gain_d_ff   <= 16'd0;
         limit_ff    <= 23'd655360;
         weight_ff   <= 16'd62915;
         mag_low_ff  <= 17'd8192;
         mag_high_ff <= 17'd32768;
         pitch_ff    <= '0;
         roll_ff     <= '0;
         integ_ff    <= '0;
         prev_ff     <= '0;
         axis_ff     <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN_P:       gain_p_ff   <= csr_data[15:0];
               REG_GAIN_I:       gain_i_ff   <= csr_data[15:0];
               REG_GAIN_D:       gain_d_ff   <= csr_data[15:0];
               REG_DRIVE_LIMIT:  limit_ff    <= csr_data[22:0];
               REG_BLEND_WEIGHT: weight_ff   <= csr_data[15:0];
               REG_MAG_LOW:      mag_low_ff  <= csr_data[16:0];
               REG_MAG_HIGH:     mag_high_ff <= csr_data[16:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall && state_ff != S_OUT) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff    <= req_accel_x;
                  ay_ff    <= req_accel_y;
                  az_ff    <= req_accel_z;
                  gx_ff    <= req_gyro_x;
                  gy_ff    <= req_gyro_y;
                  blend_ff <= mag > mag_low_ff && mag < mag_high_ff;
                  axis_ff  <= 1'b0;
                  state_ff <= S_G_MUL;
               end
            end
            S_G_MUL: begin
               rq_ff    <= rec_prod[62:36];
               neg_ff   <= rec_neg;
               state_ff <= S_G_ADD;
            end
            S_G_ADD: begin
               if (axis_ff) roll_ff <= sat_v[24:0];
               else pitch_ff <= sat_v[24:0];
               axis_ff <= !axis_ff;
               if (!axis_ff) state_ff <= S_G_MUL;
               else if (blend_ff) state_ff <= S_C_START;
               else state_ff <= S_K_P;
            end
            S_C_START: state_ff <= S_C_WAIT;
            S_C_WAIT: begin
               if (cor_done) begin
                  acc_ff   <= cor_angle;
                  state_ff <= S_B_MUL1;
               end
            end
            S_B_MUL1: state_ff <= S_B_MUL2;
            S_B_MUL2: begin
               bsum_ff  <= prod_ff;
               state_ff <= S_B_SUM;
            end
            S_B_SUM: begin
               if (axis_ff) roll_ff <= blend_v[24:0];
               else pitch_ff <= blend_v[24:0];
               axis_ff  <= !axis_ff;
               state_ff <= axis_ff ? S_K_P : S_C_START;
            end
            S_K_P: state_ff <= S_K_I;
            S_K_I: begin
               p_ff     <= 34'((-prod_ff) >>> 8);
               state_ff <= S_I_MUL;
            end
            S_I_MUL: begin
               rq_ff    <= rec_prod[62:36];
               neg_ff   <= rec_neg;
               state_ff <= S_I_ADD;
            end
            S_I_ADD: begin
               integ_ff <= integ_v[23:0];
               state_ff <= S_K_D;
            end
            S_K_D: state_ff <= S_D_SUM;
            S_D_SUM: begin
               d_ff     <= d_t[41:0];
               state_ff <= S_DRIVE;
            end
            S_DRIVE: begin
               drive_ff <= drive_v[23:0];
               prev_ff  <= pitch_ff;
               if (drive_v == 48'sd0) begin
                  period_ff <= 16'hFFFF;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_PER_START;
               end
            end
            S_PER_START: state_ff <= S_PER_WAIT;
            S_PER_WAIT: begin
               if (div_rsp.done) begin
                  period_ff <= (div_rsp.quo > 42'd65535) ? 16'hFFFF : div_rsp.quo[15:0];
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid         <= 1'b1;
                  rsp_pitch_out     <= pitch_ff;
                  rsp_roll_out      <= roll_ff;
                  rsp_drive_value   <= drive_ff;
                  rsp_step_period   <= period_ff;
                  rsp_accel_blended <= blend_ff;
                  if (drive_ff == 24'sd0) rsp_drive_direction <= DIR_HOLD;
                  else if (drive_ff[23]) rsp_drive_direction <= DIR_BACKWARD;
                  else rsp_drive_direction <= DIR_FORWARD;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block idle right after a transaction was accepted");

   a_dir_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_direction == DIR_HOLD) == (rsp_drive_value == 24'sd0)))
      else $error("direction disagrees with drive value");

   a_period_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_value == 24'sd0 |-> rsp_step_period == 16'hFFFF)
      else $error("zero drive without saturated period");

   a_no_load_while_stalled: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid && rsp_stall |=> state_ff == S_OUT)
      else $error("result dropped while output stalled");

endmodule
